[design/sap_pkg.sv]
`timescale 1ns / 1ps

package sap_pkg;

	// Field widths.
	localparam int unsigned TARGET_W = 12;
	localparam int unsigned ANGLE_W  = 9;
	localparam int unsigned SPR_W    = 13;
	localparam int unsigned SDEG_W   = 7;
	localparam int unsigned COIL_W   = 8;
	localparam int unsigned CIDX_W   = 2;
	localparam int unsigned CFG_W    = 13;

	// The remaining move is kept as degree-steps: steps_left = rem / 360.
	localparam int unsigned REM_W = 25;

	typedef logic [TARGET_W-1:0] target_t;
	typedef logic [ANGLE_W-1:0]  angle_t;
	typedef logic [SPR_W-1:0]    spr_t;
	typedef logic [SDEG_W-1:0]   sdeg_t;
	typedef logic [COIL_W-1:0]   coil_t;
	typedef logic [CIDX_W-1:0]   cidx_t;
	typedef logic [CFG_W-1:0]    cfg_data_t;
	typedef logic [REM_W-1:0]    rem_t;

	// Configuration register indexes.
	typedef enum logic [0:0] {
		CFG_STEPS_PER_REV = 1'b0,
		CFG_STEP_DEGREES  = 1'b1
	} cfg_index_t;

	localparam spr_t  SPR_RESET  = 13'd48;
	localparam sdeg_t SDEG_RESET = 7'd8;

	localparam angle_t FULL_TURN = 9'd360;
	localparam rem_t   REM_STEP  = 25'd360;

	// A relative move of more than 65535 steps saturates to 65535 steps.
	localparam rem_t REM_SAT_LIMIT = 25'd23592960;
	localparam rem_t REM_SAT_VALUE = 25'd23592600;

	// Full-step coil drive patterns.
	function automatic coil_t coil_pattern(input cidx_t idx);
		coil_t pat;
		case (idx)
			2'd0:    pat = 8'hF9;
			2'd1:    pat = 8'hFC;
			2'd2:    pat = 8'hF6;
			2'd3:    pat = 8'hF3;
			default: pat = 8'hF9;
		endcase
		return pat;
	endfunction

endpackage

[design/sap_tick_if.sv]
`timescale 1ns / 1ps

interface sap_tick_if;
	logic               valid;
	logic               ready;
	sap_pkg::target_t   target_angle;
	logic               absolute_mode;

	modport source(output valid, output target_angle, output absolute_mode, input ready);
	modport sink(input valid, input target_angle, input absolute_mode, output ready);
endinterface

[design/sap_drive_if.sv]
`timescale 1ns / 1ps

interface sap_drive_if;
	logic             valid;
	logic             ready;
	sap_pkg::coil_t   coil_word;
	logic             moving;
	sap_pkg::angle_t  current_angle;

	modport source(output valid, output coil_word, output moving, output current_angle,
		input ready);
	modport sink(input valid, input coil_word, input moving, input current_angle,
		output ready);
endinterface

[design/stepper_angle_positioner.sv]
// Path: a tick's result passes the input register and then the output register before it is offered.
// Throughput: one tick per cycle while the drive side is ready; the update of angle, direction and
// remaining move (one 9x13 multiply on a new absolute move) in one pass sets that figure.
// Reset: arst_n low clears the move, angle, coil index and direction at once and
// returns steps_per_rev to 48 and step_degrees to 8; no clearing pass is needed.
`timescale 1ns / 1ps

module stepper_angle_positioner (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_wr_en,
	input  sap_pkg::cfg_index_t  cfg_index,
	input  sap_pkg::cfg_data_t   cfg_data,
	sap_tick_if.sink             tick,
	sap_drive_if.source          drive
);

	// Target angle modulo a full turn, by parallel compares against multiples of 360.
	function automatic sap_pkg::angle_t mod_full_turn(input sap_pkg::target_t v);
		sap_pkg::target_t r;
		r = v;
		for (int k = 1; k <= 11; k++) begin
			if (v >= sap_pkg::target_t'(k * 360)) begin
				r = v - sap_pkg::target_t'(k * 360);
			end
		end
		return sap_pkg::angle_t'(r);
	endfunction

	// Configuration registers.
	sap_pkg::spr_t  spr_q;
	sap_pkg::sdeg_t sdeg_q;

	// Input stage.
	logic            valid_s1;
	logic            abs_s1;
	sap_pkg::angle_t tmod_s1;
	sap_pkg::rem_t   prel_s1;

	// Motor state.
	sap_pkg::rem_t   rem_q;
	sap_pkg::angle_t track_q;
	sap_pkg::cidx_t  coil_q;
	logic            dec_q;

	// Output stage.
	logic            valid_s2;
	sap_pkg::coil_t  coil_word_s2;
	logic            moving_s2;
	sap_pkg::angle_t angle_s2;

	logic            advance;
	logic            adv_item;
	logic            in_xfer;
	sap_pkg::angle_t tmod_in;
	sap_pkg::rem_t   prel_raw;
	sap_pkg::rem_t   prel_in;

	sap_pkg::angle_t direct;
	sap_pkg::angle_t around;
	sap_pkg::angle_t abs_deg;
	logic            abs_dec;
	logic [21:0]     abs_prod;
	logic            idle_move;
	logic            dir_sel;
	sap_pkg::rem_t   rem_cur;
	sap_pkg::rem_t   rem_next;
	logic            step;
	logic [9:0]      inc_sum;
	sap_pkg::angle_t inc_angle;
	sap_pkg::angle_t dec_angle;
	sap_pkg::angle_t track_next;
	sap_pkg::cidx_t  coil_next;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			spr_q  <= sap_pkg::SPR_RESET;
			sdeg_q <= sap_pkg::SDEG_RESET;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				sap_pkg::CFG_STEPS_PER_REV: spr_q  <= cfg_data;
				sap_pkg::CFG_STEP_DEGREES:  sdeg_q <= cfg_data[sap_pkg::SDEG_W-1:0];
				default: ;
			endcase
		end
	end

	// Handshake: the output register frees up when empty or when its transfer completes.
	assign advance    = !valid_s2 || drive.ready;
	assign adv_item   = valid_s1 && advance;
	assign tick.ready = !valid_s1 || advance;
	assign in_xfer    = tick.valid && tick.ready;

	// State-independent work done ahead of the input register.
	assign tmod_in  = mod_full_turn(tick.target_angle);
	assign prel_raw = sap_pkg::rem_t'(tick.target_angle) * sap_pkg::rem_t'(spr_q);
	assign prel_in  = (prel_raw >= sap_pkg::REM_SAT_LIMIT) ? sap_pkg::REM_SAT_VALUE : prel_raw;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (tick.ready) begin
			valid_s1 <= tick.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			abs_s1  <= tick.absolute_mode;
			tmod_s1 <= tmod_in;
			prel_s1 <= prel_in;
		end
	end

	// Shortest way to an absolute target; a half turn goes the direct way.
	always_comb begin
		direct  = '0;
		around  = '0;
		abs_deg = '0;
		abs_dec = dec_q;
		if (tmod_s1 > track_q) begin
			direct = tmod_s1 - track_q;
			around = sap_pkg::FULL_TURN - direct;
			if (direct > around) begin
				abs_dec = 1'b1;
				abs_deg = around;
			end else begin
				abs_dec = 1'b0;
				abs_deg = direct;
			end
		end else if (tmod_s1 < track_q) begin
			direct = track_q - tmod_s1;
			around = sap_pkg::FULL_TURN - direct;
			if (direct > around) begin
				abs_dec = 1'b0;
				abs_deg = around;
			end else begin
				abs_dec = 1'b1;
				abs_deg = direct;
			end
		end
	end

	assign abs_prod = 22'(abs_deg) * 22'(spr_q);

	// A new move loads only when less than one step remains.
	assign idle_move = rem_q < sap_pkg::REM_STEP;
	assign dir_sel   = (idle_move && abs_s1) ? abs_dec : dec_q;
	assign rem_cur   = idle_move ? (abs_s1 ? sap_pkg::rem_t'(abs_prod) : prel_s1) : rem_q;
	assign step      = rem_cur >= sap_pkg::REM_STEP;
	assign rem_next  = step ? (rem_cur - sap_pkg::REM_STEP) : rem_cur;

	// Angle tracking with wrap in one full turn.
	assign inc_sum   = 10'(track_q) + 10'(sdeg_q);
	assign inc_angle = (inc_sum >= 10'(sap_pkg::FULL_TURN))
		? 9'(inc_sum - 10'(sap_pkg::FULL_TURN)) : 9'(inc_sum);
	assign dec_angle = (track_q >= 9'(sdeg_q))
		? (track_q - 9'(sdeg_q))
		: 9'(10'(track_q) + 10'(sap_pkg::FULL_TURN) - 10'(sdeg_q));

	assign track_next = step ? (dir_sel ? dec_angle : inc_angle) : track_q;
	assign coil_next  = step ? (dir_sel ? (coil_q - 2'd1) : (coil_q + 2'd1)) : coil_q;

	// Motor state update, once per item that moves to the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q   <= '0;
			track_q <= '0;
			coil_q  <= '0;
			dec_q   <= 1'b0;
		end else if (adv_item) begin
			rem_q   <= rem_next;
			track_q <= track_next;
			coil_q  <= coil_next;
			dec_q   <= dir_sel;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_item) begin
			coil_word_s2 <= sap_pkg::coil_pattern(coil_next);
			moving_s2    <= step;
			angle_s2     <= track_next;
		end
	end

	assign drive.valid         = valid_s2;
	assign drive.coil_word     = coil_word_s2;
	assign drive.moving        = moving_s2;
	assign drive.current_angle = angle_s2;

`ifndef SYNTHESIS
	// The tracked angle never leaves one full turn.
	assert property (@(posedge clk) disable iff (!arst_n)
		track_q < sap_pkg::FULL_TURN)
		else $error("tracked angle out of range");

	// A pending move loses exactly one step per item.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_item && !idle_move) |=> (rem_q == $past(rem_q) - sap_pkg::REM_STEP))
		else $error("pending move not counted down by one step");

	// Every issued step moves the coil index and is reported as moving.
	assert property (@(posedge clk) disable iff (!arst_n)
		(adv_item && step) |=> (coil_q != $past(coil_q)) && drive.valid && drive.moving)
		else $error("step issued without coil advance or moving flag");
`endif

endmodule

[tb/stepper_angle_positioner_tb.sv]
`timescale 1ns / 1ps

module stepper_angle_positioner_tb;

	// One drive transfer as the block should produce it.
	typedef struct packed {
		sap_pkg::coil_t  coil_word;
		logic            moving;
		sap_pkg::angle_t current_angle;
	} drive_item_t;

	// Tracks the motor state, predicts each tick's drive output and checks the results.
	class positioner_scoreboard;
		localparam int unsigned MAX_STEPS = 65535;
		localparam int unsigned DEGREES   = 360;
		localparam int unsigned REPORT_MAX = 10;

		sap_pkg::spr_t   spr;
		sap_pkg::sdeg_t  sdeg;
		sap_pkg::angle_t angle;
		sap_pkg::cidx_t  cidx;
		int unsigned     steps_left;
		logic            decreasing;
		sap_pkg::coil_t  coil_seq[4];
		drive_item_t     pending_drives[$];
		int unsigned     errors;

		function new();
			coil_seq = '{8'hF9, 8'hFC, 8'hF6, 8'hF3};
			spr = sap_pkg::SPR_RESET;
			sdeg = sap_pkg::SDEG_RESET;
			angle = '0;
			cidx = '0;
			steps_left = 0;
			decreasing = 1'b0;
			errors = 0;
		endfunction

		function void write_reg(sap_pkg::cfg_index_t idx, sap_pkg::cfg_data_t data);
			if (idx == sap_pkg::CFG_STEPS_PER_REV) begin
				spr = data[sap_pkg::SPR_W-1:0];
			end else begin
				sdeg = data[sap_pkg::SDEG_W-1:0];
			end
		endfunction

		// Degrees along the shorter way to an absolute target; picks the direction too.
		function int unsigned shortest_turn(sap_pkg::target_t tgt);
			int unsigned t;
			int unsigned a;
			int unsigned direct;
			int unsigned around;
			t = tgt % DEGREES;
			a = angle;
			if (t == a) begin
				return 0;
			end
			if (t > a) begin
				direct = t - a;
				around = DEGREES - t + a;
				decreasing = (direct > around);
			end else begin
				direct = a - t;
				around = DEGREES - a + t;
				decreasing = !(direct > around);
			end
			return (direct > around) ? around : direct;
		endfunction

		// Advances the motor by one tick and queues the drive output it causes.
		function void note_tick(sap_pkg::target_t tgt, logic abs_mode);
			int unsigned deg;
			int unsigned count;
			int unsigned next_angle;
			logic        stepped;
			drive_item_t item;
			stepped = 1'b0;
			if (steps_left == 0) begin
				deg = abs_mode ? shortest_turn(tgt) : int'(tgt);
				count = deg * int'(spr) / DEGREES;
				steps_left = (count > MAX_STEPS) ? MAX_STEPS : count;
			end
			if (steps_left != 0) begin
				stepped = 1'b1;
				if (!decreasing) begin
					cidx = cidx + 2'd1;
					next_angle = int'(angle) + int'(sdeg);
					if (next_angle >= DEGREES) begin
						next_angle = next_angle - DEGREES;
					end
				end else begin
					cidx = cidx - 2'd1;
					if (angle >= sdeg) begin
						next_angle = int'(angle) - int'(sdeg);
					end else begin
						next_angle = int'(angle) + DEGREES - int'(sdeg);
					end
				end
				angle = sap_pkg::angle_t'(next_angle);
				steps_left = steps_left - 1;
			end
			item.coil_word = coil_seq[cidx];
			item.moving = stepped;
			item.current_angle = angle;
			pending_drives.push_back(item);
		endfunction

		function void check_drive(sap_pkg::coil_t coil_word, logic moving,
				sap_pkg::angle_t current_angle);
			drive_item_t want;
			if (pending_drives.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$display("%0t: unexpected drive: coil %h moving %0d angle %0d",
						$time, coil_word, moving, current_angle);
				end
				return;
			end
			want = pending_drives.pop_front();
			if (want.coil_word !== coil_word || want.moving !== moving
					|| want.current_angle !== current_angle) begin
				errors++;
				if (errors <= REPORT_MAX) begin
					$display("%0t: drive mismatch: coil exp %h got %h, moving exp %0d got %0d",
						$time, want.coil_word, coil_word, want.moving, moving);
					$display("%0t: drive mismatch: angle exp %0d got %0d",
						$time, want.current_angle, current_angle);
				end
			end
		endfunction

		function bit idle();
			return pending_drives.size() == 0;
		endfunction
	endclass

	logic                clk;
	logic                arst_n;
	logic                cfg_wr_en;
	sap_pkg::cfg_index_t cfg_index;
	sap_pkg::cfg_data_t  cfg_data;

	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	logic        hold_req;

	positioner_scoreboard sb;

	sap_tick_if  tick_ch();
	sap_drive_if drive_ch();

	stepper_angle_positioner DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.tick(tick_ch),
		.drive(drive_ch)
	);

	// Clock.
	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit.
	initial begin
		#(20_000_000);
		$display("Test completed with failures");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off when requested.
	initial begin : receiver
		int unsigned hold_left;
		bit          hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		drive_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req && !hold_used) begin
				hold_used = 1'b1;
				hold_left = 64;
			end
			if (hold_left != 0) begin
				hold_left--;
				drive_ch.ready <= 1'b0;
			end else begin
				drive_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	// Check every drive transfer.
	always @(posedge clk) begin
		if (arst_n && drive_ch.valid === 1'b1 && drive_ch.ready === 1'b1) begin
			sb.check_drive(drive_ch.coil_word, drive_ch.moving, drive_ch.current_angle);
		end
	end

	// Offers one tick and returns at the falling edge after its transfer.
	task automatic send_tick(input sap_pkg::target_t tgt, input logic abs_mode);
		while ($urandom_range(99) < tx_idle_pct) begin
			tick_ch.valid <= 1'b0;
			@(negedge clk);
		end
		tick_ch.valid <= 1'b1;
		tick_ch.target_angle <= tgt;
		tick_ch.absolute_mode <= abs_mode;
		do begin
			@(posedge clk);
		end while (tick_ch.ready !== 1'b1);
		sb.note_tick(tgt, abs_mode);
		@(negedge clk);
	endtask

	// Loads a move, then keeps ticking with random content until it has run out.
	task automatic send_move(input sap_pkg::target_t tgt, input logic abs_mode);
		send_tick(tgt, abs_mode);
		while (sb.steps_left != 0) begin
			send_tick(sap_pkg::target_t'($urandom), logic'($urandom_range(1)));
		end
	endtask

	task automatic wait_drive_empty();
		if (tick_ch.valid !== 1'b0) begin
			tick_ch.valid <= 1'b0;
		end
		while (!sb.idle()) begin
			@(negedge clk);
		end
	endtask

	// Register write; only issued once every pending drive transfer has arrived.
	task automatic write_config(input sap_pkg::cfg_index_t idx,
			input sap_pkg::cfg_data_t data);
		wait_drive_empty();
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		@(negedge clk);
	endtask

	task automatic configure(input int unsigned spr_val, input int unsigned sdeg_val);
		write_config(sap_pkg::CFG_STEPS_PER_REV, sap_pkg::cfg_data_t'(spr_val));
		write_config(sap_pkg::CFG_STEP_DEGREES, sap_pkg::cfg_data_t'(sdeg_val));
	endtask

	task automatic run_directed();
		// Idle ticks: zero relative turn, absolute target equal to the angle; then a relative move.
		send_move(12'd0, 1'b0);
		send_move(12'd0, 1'b1);
		send_move(12'd720, 1'b1);
		send_move(12'd45, 1'b0);
		// Half-turn ties, target above and then below the tracked angle.
		send_move(sap_pkg::target_t'((sb.angle + 180) % 360), 1'b1);
		send_move(sap_pkg::target_t'((sb.angle + 180) % 360), 1'b1);
		// Shorter way round, crossing zero downward and then upward.
		send_move(sap_pkg::target_t'((sb.angle + 300) % 360), 1'b1);
		send_move(sap_pkg::target_t'((sb.angle + 60) % 360), 1'b1);
		send_move(12'd4095, 1'b1);
		// A relative turn keeps the direction an absolute move set.
		send_move(sap_pkg::target_t'((sb.angle + 350) % 360), 1'b1);
		send_move(12'd90, 1'b0);

		// One step per revolution: short absolute moves give no steps but turn the direction.
		configure(1, 1);
		send_move(sap_pkg::target_t'((sb.angle + 10) % 360), 1'b1);
		send_move(sap_pkg::target_t'((sb.angle + 200) % 360), 1'b1);
		send_move(12'd4095, 1'b0);
		send_move(sap_pkg::target_t'(sb.angle + 360), 1'b1);
		send_move(12'd720, 1'b0);

		// No steps per revolution; step size with stray upper data bits.
		write_config(sap_pkg::CFG_STEPS_PER_REV, '0);
		write_config(sap_pkg::CFG_STEP_DEGREES, 13'h1FFF);
		send_move(12'd4095, 1'b0);
		send_move(sap_pkg::target_t'((sb.angle + 90) % 360), 1'b1);

		configure(4096, 90);
		send_move(12'd1, 1'b0);
		send_move(sap_pkg::target_t'((sb.angle + 357) % 360), 1'b1);

		configure(8191, 127);
		send_move(12'd1, 1'b0);

		configure(48, 0);
		send_move(12'd30, 1'b0);
	endtask

	// One random move, kept short unless the revolution is coarse.
	task automatic random_load();
		int unsigned      cap;
		int unsigned      off;
		sap_pkg::target_t tgt;
		logic             abs_mode;
		cap = (sb.spr == 0) ? 4095 : 8640 / int'(sb.spr) + 1;
		if (cap > 4095) begin
			cap = 4095;
		end
		abs_mode = ($urandom_range(99) < 40);
		if (sb.spr <= 16 && $urandom_range(19) == 0) begin
			tgt = sap_pkg::target_t'($urandom);
		end else if (!abs_mode) begin
			tgt = ($urandom_range(9) == 0) ? '0 : sap_pkg::target_t'($urandom_range(cap, 0));
		end else if (sb.spr <= 64) begin
			tgt = sap_pkg::target_t'($urandom);
		end else begin
			off = $urandom_range((cap > 180) ? 180 : cap, 0);
			if ($urandom_range(1) == 1) begin
				off = 360 - off;
			end
			tgt = sap_pkg::target_t'((sb.angle + off) % 360 + 360 * $urandom_range(10, 0));
		end
		send_move(tgt, abs_mode);
	endtask

	// New random register setting, then a run of moves.
	task automatic run_segment(input int unsigned loads, input bit pause_midway);
		int unsigned spr_val;
		int unsigned sdeg_val;
		int unsigned i;
		case ($urandom_range(9))
			0: spr_val = 1;
			1: spr_val = 4096;
			2: spr_val = 0;
			3: spr_val = 8191;
			default: spr_val = $urandom_range(64, 1);
		endcase
		case ($urandom_range(9))
			0: sdeg_val = 1;
			1: sdeg_val = 90;
			2: sdeg_val = 0;
			3: sdeg_val = 127;
			default: sdeg_val = $urandom_range(90, 1);
		endcase
		if ($urandom_range(3) == 0) begin
			sdeg_val = sdeg_val | ($urandom & 32'h1F80);
		end
		configure(spr_val, sdeg_val);
		for (i = 0; i < loads; i++) begin
			// The sender holds back until the block has delivered everything.
			if (pause_midway && i == loads / 2) begin
				wait_drive_empty();
			end
			random_load();
		end
	endtask

	initial begin
		sb = new();
		arst_n = 1'b0;
		cfg_wr_en = 1'b0;
		cfg_index = sap_pkg::CFG_STEPS_PER_REV;
		cfg_data = '0;
		tick_ch.valid = 1'b0;
		tick_ch.target_angle = '0;
		tick_ch.absolute_mode = 1'b0;
		hold_req = 1'b0;
		tx_idle_pct = 7;
		rx_idle_pct = 72;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Sender mostly busy, receiver mostly stalled.
		run_directed();
		repeat (3) run_segment(3, 1'b0);

		// Sender mostly idle, receiver mostly ready.
		wait_drive_empty();
		tx_idle_pct = 72;
		rx_idle_pct = 7;
		run_segment(3, 1'b1);
		repeat (2) run_segment(3, 1'b0);

		// Full rate, with one long receiver hold-off to back up the input.
		wait_drive_empty();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_req = 1'b1;
		repeat (3) run_segment(3, 1'b0);

		// Step count just past the limit saturates instead of wrapping to zero;
		// the first ticks of that move must already step.
		write_config(sap_pkg::CFG_STEPS_PER_REV, 13'd6144);
		send_tick(12'd3840, 1'b0);
		repeat (20) send_tick(sap_pkg::target_t'($urandom), logic'($urandom_range(1)));

		wait_drive_empty();
		repeat (10) @(negedge clk);
		if (sb.errors == 0 && sb.idle()) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
